>>> hw/rtl/atr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atr_pkg;

   localparam int IDX_W        = 5;
   localparam int ATAN_ENTRIES = 24;
   localparam int VEC_W        = 36;
   localparam int ACC_W        = 26;
   localparam int ROOT_W       = 32;
   localparam int REM_W        = 36;
   localparam int RND_W        = ACC_W - 8;

   localparam logic signed [ACC_W-1:0] DEG180_ACC  = 26'sd5898240;
   localparam logic signed [RND_W-1:0] ROLL_LIMIT  = 18'sd23040;
   localparam logic signed [RND_W-1:0] PITCH_LIMIT = 18'sd11520;
   localparam logic [14:0]             THRESH_RESET = 15'd3840;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_ADD,
      ST_ROOT,
      ST_P_LOAD,
      ST_P_ROT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             sq_y;
      logic             sq_z;
      logic             sq_add;
      logic             root_step;
      logic             cor_load;
      logic             cor_pitch;
      logic             cor_step;
      logic [IDX_W-1:0] cor_idx;
      logic             roll_store;
      logic             result_store;
   } cmd_type;

   // atan(2^-i) in degrees, scaled by 2^15
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 26'sd1474560;
         5'd1:    val = 26'sd870484;
         5'd2:    val = 26'sd459940;
         5'd3:    val = 26'sd233473;
         5'd4:    val = 26'sd117189;
         5'd5:    val = 26'sd58652;
         5'd6:    val = 26'sd29333;
         5'd7:    val = 26'sd14667;
         5'd8:    val = 26'sd7334;
         5'd9:    val = 26'sd3667;
         5'd10:   val = 26'sd1833;
         5'd11:   val = 26'sd917;
         5'd12:   val = 26'sd458;
         5'd13:   val = 26'sd229;
         5'd14:   val = 26'sd115;
         5'd15:   val = 26'sd57;
         5'd16:   val = 26'sd29;
         5'd17:   val = 26'sd14;
         5'd18:   val = 26'sd7;
         5'd19:   val = 26'sd4;
         5'd20:   val = 26'sd2;
         5'd21:   val = 26'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/atr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module atr_ctrl
   import atr_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   localparam int USED  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int CNT_W = ($clog2(USED + 2) > IDX_W) ? $clog2(USED + 2) : IDX_W;

   state_type        state_ff, state_in;
   logic [4:0]       root_cnt_ff, root_cnt_in;
   logic [CNT_W-1:0] rot_cnt_ff, rot_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_SQ_Z;
         ST_SQ_Z:   state_in = ST_SQ_ADD;
         ST_SQ_ADD: state_in = ST_ROOT;
         ST_ROOT:   if (root_cnt_ff == 5'd31) state_in = ST_P_LOAD;
         ST_P_LOAD: state_in = ST_P_ROT;
         ST_P_ROT:  if (rot_cnt_ff == CNT_W'(USED - 1)) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd          = '0;
      cmd.cor_idx  = rot_cnt_ff[IDX_W-1:0];
      root_cnt_in  = root_cnt_ff;
      rot_cnt_in   = rot_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_SQ_Y: begin
            cmd.sq_y     = 1'b1;
            cmd.cor_load = 1'b1;
            rot_cnt_in   = '0;
         end
         ST_SQ_Z: begin
            cmd.sq_z = 1'b1;
         end
         ST_SQ_ADD: begin
            cmd.sq_add  = 1'b1;
            root_cnt_in = '0;
         end
         ST_ROOT: begin
            // roll rotations run alongside the square root
            cmd.root_step = 1'b1;
            root_cnt_in   = root_cnt_ff + 5'd1;
            if (rot_cnt_ff < CNT_W'(USED)) begin
               cmd.cor_step = 1'b1;
               rot_cnt_in   = rot_cnt_ff + 1'b1;
            end else if (rot_cnt_ff == CNT_W'(USED)) begin
               cmd.roll_store = 1'b1;
               rot_cnt_in     = rot_cnt_ff + 1'b1;
            end
         end
         ST_P_LOAD: begin
            cmd.cor_load  = 1'b1;
            cmd.cor_pitch = 1'b1;
            rot_cnt_in    = '0;
         end
         ST_P_ROT: begin
            cmd.cor_step = 1'b1;
            rot_cnt_in   = rot_cnt_ff + 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.result_store = 1'b1;
               rsp_valid_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_cnt_ff  <= '0;
         rot_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_cnt_ff  <= root_cnt_in;
         rot_cnt_ff   <= rot_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/atr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module atr_datapath
   import atr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic               csr_wr_en,
   input  wire logic        [14:0] csr_wr_data,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   output logic signed      [15:0] rsp_roll_angle,
   output logic signed      [14:0] rsp_pitch_angle,
   output logic                    rsp_wrist_raised
);

   // captured sample
   logic signed [15:0] ax_ff, ay_ff, az_ff;

   // squares
   logic signed [15:0] mul_op;
   logic signed [31:0] product;
   logic [30:0]        prod_ff, prod_in;
   logic [30:0]        sum_ff, sum_in;

   // square root, one result bit a cycle
   logic [31:0]        sq_ff, sq_in;
   logic [REM_W-1:0]   rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0]  root_ff, root_in;

   // shared CORDIC vectoring unit
   logic signed [VEC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [VEC_W-1:0] lx, ly, dx, dy;
   logic signed [ACC_W-1:0] acc_ff, acc_in, step_ang, acc_rnd;
   logic                    zero_ff, zero_in;
   logic signed [RND_W-1:0] rnd;

   logic signed [15:0] roll_ff, roll_in, roll_sat;
   logic signed [14:0] pitch_sat;
   logic signed [14:0] prev_pitch_ff;
   logic               have_prev_ff;
   logic [14:0]        thresh_ff;
   logic signed [15:0] diff;
   logic [15:0]        mag;
   logic               flag;

   logic signed [15:0] roll_out_ff;
   logic signed [14:0] pitch_out_ff;
   logic               flag_out_ff;

   assign mul_op  = cmd.sq_z ? az_ff : ay_ff;
   assign product = mul_op * mul_op;

   always_comb begin
      prod_in = prod_ff;
      sum_in  = sum_ff;
      if (cmd.sq_y || cmd.sq_z) prod_in = product[30:0];
      if (cmd.sq_z) sum_in = prod_ff;
   end

   assign rem_sh = {rem_ff[REM_W-3:0], sq_ff[31:30]};
   assign trial  = {{(REM_W - ROOT_W - 2){1'b0}}, root_ff, 2'b01};

   always_comb begin
      sq_in   = sq_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sq_add) begin
         sq_in   = {1'b0, sum_ff} + {1'b0, prod_ff};
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         sq_in = {sq_ff[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (cmd.cor_pitch) begin
         lx = {{(VEC_W - ROOT_W){1'b0}}, root_ff};
         ly = -{{(VEC_W - 32){ax_ff[15]}}, ax_ff, 16'b0};
      end else begin
         lx = {{(VEC_W - 32){az_ff[15]}}, az_ff, 16'b0};
         ly = {{(VEC_W - 32){ay_ff[15]}}, ay_ff, 16'b0};
      end
   end

   assign dx       = cy_ff >>> cmd.cor_idx;
   assign dy       = cx_ff >>> cmd.cor_idx;
   assign step_ang = atan_entry(cmd.cor_idx);

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      acc_in  = acc_ff;
      zero_in = zero_ff;
      if (cmd.cor_load) begin
         zero_in = (lx == '0) && (ly == '0);
         if (lx < 0) begin
            // left half plane: fold over and start from 180 degrees
            acc_in = (ly >= 0) ? DEG180_ACC : -DEG180_ACC;
            cx_in  = -lx;
            cy_in  = -ly;
         end else begin
            acc_in = '0;
            cx_in  = lx;
            cy_in  = ly;
         end
      end else if (cmd.cor_step) begin
         if (cy_ff >= 0) begin
            cx_in  = cx_ff + dx;
            cy_in  = cy_ff - dy;
            acc_in = acc_ff + step_ang;
         end else begin
            cx_in  = cx_ff - dx;
            cy_in  = cy_ff + dy;
            acc_in = acc_ff - step_ang;
         end
      end
   end

   // round to 1/128 degree, ties upward
   assign acc_rnd = acc_ff + ACC_W'(128);
   assign rnd     = acc_rnd[ACC_W-1:8];

   always_comb begin
      if (zero_ff) begin
         roll_sat = '0;
      end else if (rnd > ROLL_LIMIT) begin
         roll_sat = ROLL_LIMIT[15:0];
      end else if (rnd < -ROLL_LIMIT) begin
         roll_sat = -ROLL_LIMIT[15:0];
      end else begin
         roll_sat = rnd[15:0];
      end
   end

   always_comb begin
      if (zero_ff) begin
         pitch_sat = '0;
      end else if (rnd > PITCH_LIMIT) begin
         pitch_sat = PITCH_LIMIT[14:0];
      end else if (rnd < -PITCH_LIMIT) begin
         pitch_sat = -PITCH_LIMIT[14:0];
      end else begin
         pitch_sat = rnd[14:0];
      end
   end

   assign roll_in = cmd.roll_store ? roll_sat : roll_ff;
   assign diff    = {pitch_sat[14], pitch_sat} - {prev_pitch_ff[14], prev_pitch_ff};
   assign mag     = diff[15] ? 16'(-diff) : 16'(diff);
   assign flag    = have_prev_ff && (mag > {1'b0, thresh_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_in;
      roll_ff <= roll_in;
      if (cmd.result_store) begin
         roll_out_ff  <= roll_ff;
         pitch_out_ff <= pitch_sat;
         flag_out_ff  <= flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= THRESH_RESET;
         prev_pitch_ff <= '0;
         have_prev_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) thresh_ff <= csr_wr_data;
         if (cmd.result_store) begin
            prev_pitch_ff <= pitch_sat;
            have_prev_ff  <= 1'b1;
         end
      end
   end

   assign rsp_roll_angle   = roll_out_ff;
   assign rsp_pitch_angle  = pitch_out_ff;
   assign rsp_wrist_raised = flag_out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/accel_tilt_wrist_raise.sv
// Tilt angles and wrist-raise detect from one accelerometer sample.
// Input channel req_*: valid/ready, one item = signed x, y, z axes.
// Result channel rsp_*: valid/ready, one item per input item with roll,
// pitch (1/128 degree) and the wrist-raise flag.
// csr_wr_en/csr_wr_data write the 15-bit pitch-change threshold; write
// only while the block is idle.
// Each item runs in turn through squaring of y and z, a bit-serial
// square root (with the roll CORDIC pass running beside it) and the
// pitch CORDIC pass on the same shared rotation unit. A new item is
// accepted only while idle, so the block takes no new item until the
// last one is through.
// A finished result sits in an output register; the next item is taken
// while it waits. If the receiver stalls, the following result is held
// internally until the register frees, and no further item is accepted.
// Reset: synchronous, clears control, the previous pitch and the
// first-sample marker, and loads the threshold with 30 degrees.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_wrist_raise
   import atr_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [15:0] rsp_roll_angle,
   output logic signed      [14:0] rsp_pitch_angle,
   output logic                    rsp_wrist_raised,
   input  wire logic               csr_wr_en,
   input  wire logic        [14:0] csr_wr_data
);

   cmd_type cmd;

   atr_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   atr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .rsp_roll_angle   (rsp_roll_angle),
      .rsp_pitch_angle  (rsp_pitch_angle),
      .rsp_wrist_raised (rsp_wrist_raised)
   );

endmodule

`default_nettype wire
